>>> rtl/jpeg_chroma_fancy_upsample_unit_defines.svh
// Assertion macros shared by the chroma upsampler modules.
`ifndef JPEG_CHROMA_FANCY_UPSAMPLE_UNIT_DEFINES_SVH
`define JPEG_CHROMA_FANCY_UPSAMPLE_UNIT_DEFINES_SVH

// Condition holds at every edge outside reset.
`define JCFU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next.
`define JCFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/jcfu_pkg.sv
// Package: types, mode codes and helpers for the chroma upsampler.
`timescale 1ns / 1ps
package jcfu_pkg;

  localparam logic [1:0] MODE_VERT  = 2'd0;
  localparam logic [1:0] MODE_HORIZ = 2'd1;
  localparam logic [1:0] MODE_2X2   = 2'd2;

  localparam int MaxResults = 3;

  // input register contents, with the row state seen at acceptance
  typedef struct packed {
    logic [7:0] c;
    logic [9:0] t;
    logic       last;
    logic [9:0] p;
    logic       start;
    logic [1:0] mode;
  } item_t;

  // results of one item
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [1:0]                 count;
    logic                       last;
  } res_t;

  function automatic logic [7:0] sat8(input logic [10:0] v);
    sat8 = (v > 11'd255) ? 8'd255 : v[7:0];
  endfunction

endpackage

>>> rtl/jcfu_front.sv
// Input register, mode register and row state of the chroma upsampler.
`timescale 1ns / 1ps
`include "jpeg_chroma_fancy_upsample_unit_defines.svh"
module jcfu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    near_sample,
  input  logic [7:0]    far_sample,
  input  logic          last_in_row,
  input  logic          take,
  output logic          item_valid,
  output jcfu_pkg::item_t item
);
  import jcfu_pkg::*;

  logic [1:0] mode;
  logic [9:0] prev;
  logic       start;
  logic [9:0] t_in;
  logic       accept;

  assign t_in     = {2'b00, near_sample} + {1'b0, near_sample, 1'b0} + {2'b00, far_sample};
  assign in_stall = item_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_VERT;
      prev       <= '0;
      start      <= 1'b1;
      item_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        mode <= cfg_data;
      end
      if (accept) begin
        item_valid <= 1'b1;
        start      <= last_in_row;
        case (mode)
          MODE_VERT:  prev <= prev;
          MODE_HORIZ: prev <= {2'b00, near_sample};
          default:    prev <= t_in;
        endcase
      end else if (take) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.c     <= near_sample;
      item.t     <= t_in;
      item.last  <= last_in_row;
      item.p     <= prev;
      item.start <= start;
      item.mode  <= mode;
    end
  end

  `JCFU_ASSERT_NEXT(a_mode_write, cfg_write, mode == $past(cfg_data), "mode register missed a write")
  `JCFU_ASSERT_NEXT(a_row_start, accept && last_in_row, start, "row start not set after row end")
  `JCFU_ASSERT_NEXT(a_item_hold, item_valid && !take, item_valid && $stable(item), "held item lost")

endmodule

>>> rtl/jcfu_calc.sv
// Filter arithmetic: all result bytes of one item.
`timescale 1ns / 1ps
module jcfu_calc (
  input  jcfu_pkg::item_t item,
  output jcfu_pkg::res_t  res
);
  import jcfu_pkg::*;

  logic [12:0] c13, t13, p13;
  logic [12:0] h_a, h_b, q_x, q_y, e_s, v_s;
  logic [7:0]  h_a8, h_b8, q_x8, q_y8, e8, v8;

  assign c13 = {5'b0, item.c};
  assign t13 = {3'b0, item.t};
  assign p13 = {3'b0, item.p};

  assign h_a = (p13 << 1) + p13 + c13 + 13'd2;
  assign h_b = (c13 << 1) + c13 + p13 + 13'd2;
  assign q_x = (p13 << 1) + p13 + t13 + 13'd8;
  assign q_y = (t13 << 1) + t13 + p13 + 13'd8;
  assign e_s = t13 + 13'd2;
  assign v_s = e_s;

  assign h_a8 = sat8(h_a[12:2]);
  assign h_b8 = sat8(h_b[12:2]);
  assign q_x8 = sat8({2'b00, q_x[12:4]});
  assign q_y8 = sat8({2'b00, q_y[12:4]});
  assign e8   = sat8(e_s[12:2]);
  assign v8   = sat8(v_s[12:2]);

  always_comb begin
    res.last  = item.last;
    res.bytes = '0;
    res.count = 2'd1;
    case (item.mode)
      MODE_VERT: begin
        res.bytes[0] = v8;
      end
      MODE_HORIZ: begin
        if (item.start) begin
          res.bytes[0] = item.c;
          res.bytes[1] = item.c;
          res.count    = item.last ? 2'd2 : 2'd1;
        end else begin
          res.bytes[0] = h_a8;
          res.bytes[1] = item.last ? h_a8 : h_b8;
          res.bytes[2] = item.c;
          res.count    = item.last ? 2'd3 : 2'd2;
        end
      end
      default: begin
        if (item.start) begin
          res.bytes[0] = e8;
          res.bytes[1] = e8;
          res.count    = item.last ? 2'd2 : 2'd1;
        end else begin
          res.bytes[0] = q_x8;
          res.bytes[1] = q_y8;
          res.bytes[2] = e8;
          res.count    = item.last ? 2'd3 : 2'd2;
        end
      end
    endcase
  end

endmodule

>>> rtl/jcfu_emit.sv
// Result register and byte sequencer on the output channel.
`timescale 1ns / 1ps
`include "jpeg_chroma_fancy_upsample_unit_defines.svh"
module jcfu_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  jcfu_pkg::res_t res,
  output logic          take,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_sample,
  output logic          last_of_run,
  output logic          row_done
);
  import jcfu_pkg::*;

  logic [MaxResults-1:0][7:0] bytes;
  logic [1:0] count;
  logic [1:0] idx;
  logic       rlast;
  logic       busy;
  logic       beat;
  logic       final_beat;

  assign final_beat = (idx == (count - 2'd1));
  assign beat       = busy && !out_stall;
  assign take       = item_valid && (!busy || (beat && final_beat));

  assign out_valid   = busy;
  assign out_sample  = bytes[idx];
  assign last_of_run = final_beat;
  assign row_done    = final_beat && rlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      idx   <= '0;
      count <= 2'd1;
    end else if (take) begin
      busy  <= 1'b1;
      idx   <= '0;
      count <= res.count;
    end else if (beat) begin
      if (final_beat) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bytes <= res.bytes;
      rlast <= res.last;
    end
  end

  `JCFU_ASSERT_ALWAYS(a_idx_range, !busy || (count != 2'd0 && idx < count), "beat index out of range")
  `JCFU_ASSERT_ALWAYS(a_row_done, !(out_valid && row_done) || last_of_run, "row end not on final beat")
  `JCFU_ASSERT_NEXT(a_drain, beat && final_beat && !item_valid, !out_valid, "extra beat after run")

endmodule

>>> rtl/jpeg_chroma_fancy_upsample_unit.sv
// Top level of the JPEG fancy chroma upsampler.
// An accepted item waits in the input register until the sequencer takes it
// into the result register. Throughput: one byte per cycle on the output while
// out_stall is low; 1 result byte per item in vertical mode, 1 to 3 otherwise.
// Reset: rst clears the mode to vertical, the previous value to zero and
// marks the next item as the first of a row; both channels come up empty.
`timescale 1ns / 1ps
module jpeg_chroma_fancy_upsample_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] near_sample,
  input  logic [7:0] far_sample,
  input  logic       last_in_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_sample,
  output logic       last_of_run,
  output logic       row_done
);
  import jcfu_pkg::*;

  item_t item;
  res_t  res;
  logic  item_valid;
  logic  take;

  jcfu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .near_sample (near_sample),
    .far_sample  (far_sample),
    .last_in_row (last_in_row),
    .take        (take),
    .item_valid  (item_valid),
    .item        (item)
  );

  jcfu_calc u_calc (
    .item (item),
    .res  (res)
  );

  jcfu_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .res         (res),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .last_of_run (last_of_run),
    .row_done    (row_done)
  );

endmodule

>>> tb/jpeg_chroma_fancy_upsample_unit_tb.sv
// Testbench for the chroma upsampler: predicts every output beat and checks it in order.
`timescale 1ns / 1ps
module jpeg_chroma_fancy_upsample_unit_tb;
  import jcfu_pkg::*;

  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int unsigned ItemTarget = 460;

  typedef struct packed {
    logic [7:0] sample;
    logic       run_end;
    logic       row_end;
  } out_beat_t;

  class upsample_board;
    logic [1:0]  mode;
    logic [9:0]  prev;
    logic        row_start;
    out_beat_t   pending_beats[$];
    int unsigned errors;
    int unsigned pairs;
    int unsigned beats;

    function new();
      mode = MODE_VERT;
      prev = '0;
      row_start = 1'b1;
      errors = 0;
      pairs = 0;
      beats = 0;
    endfunction

    function void add(int unsigned v, logic run_end, logic row_end);
      out_beat_t b;
      b.sample = (v > 255) ? 8'd255 : v[7:0];
      b.run_end = run_end;
      b.row_end = row_end;
      pending_beats.push_back(b);
    endfunction

    // expected beats of one accepted sample pair
    function void note_pair(logic [7:0] near, logic [7:0] far, logic last);
      int unsigned c;
      int unsigned t;
      int unsigned p;
      c = near;
      t = 3 * c + far;
      p = prev;
      pairs++;
      if (mode == MODE_VERT) begin
        add((t + 2) >> 2, 1'b1, last);
        row_start = last;
        return;
      end
      if (mode == MODE_HORIZ) begin
        if (row_start) begin
          if (last) begin
            add(c, 1'b0, 1'b0);
            add(c, 1'b1, 1'b1);
          end else begin
            add(c, 1'b1, 1'b0);
          end
        end else if (last) begin
          add((3 * p + c + 2) >> 2, 1'b0, 1'b0);
          add((3 * p + c + 2) >> 2, 1'b0, 1'b0);
          add(c, 1'b1, 1'b1);
        end else begin
          add((3 * p + c + 2) >> 2, 1'b0, 1'b0);
          add((3 * c + p + 2) >> 2, 1'b1, 1'b0);
        end
        prev = c[9:0];
        row_start = last;
        return;
      end
      // 2x2, reserved code included
      if (row_start) begin
        add((t + 2) >> 2, !last, 1'b0);
        if (last) add((t + 2) >> 2, 1'b1, 1'b1);
      end else begin
        add((3 * p + t + 8) >> 4, 1'b0, 1'b0);
        add((3 * t + p + 8) >> 4, !last, 1'b0);
        if (last) add((t + 2) >> 2, 1'b1, 1'b1);
      end
      prev = t[9:0];
      row_start = last;
    endfunction

    function void check_beat(logic [7:0] sample, logic run_end, logic row_end);
      out_beat_t want;
      beats++;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: out_sample %0d", sample);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      if (sample !== want.sample) begin
        $error("out_sample: expected %0d, got %0d", want.sample, sample);
        errors++;
      end
      if (run_end !== want.run_end) begin
        $error("last_of_run: expected %0b, got %0b", want.run_end, run_end);
        errors++;
      end
      if (row_end !== want.row_end) begin
        $error("row_done: expected %0b, got %0b", want.row_end, row_end);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] near_sample;
  logic [7:0] far_sample;
  logic       last_in_row;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_sample;
  logic       last_of_run;
  logic       row_done;

  upsample_board board;
  bit            quiet;
  int unsigned   mode_writes;
  bit [3:0]      modes_seen;

  jpeg_chroma_fancy_upsample_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .near_sample(near_sample),
    .far_sample (far_sample),
    .last_in_row(last_in_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .last_of_run(last_of_run),
    .row_done   (row_done)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // all driving tasks start and end on a falling edge
  task automatic send_pair(input logic [7:0] near, input logic [7:0] far, input logic last);
    while (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    near_sample = near;
    far_sample = far;
    last_in_row = last;
    do @(posedge clk); while (in_stall);
    board.note_pair(near, far, last);
    @(negedge clk);
  endtask

  task automatic drain_beats();
    in_valid = 1'b0;
    while (board.pending_beats.size() != 0) @(negedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain_beats();
    cfg_write = 1'b1;
    cfg_data = m;
    @(negedge clk);
    cfg_write = 1'b0;
    board.mode = m;
    mode_writes++;
    modes_seen[m] = 1'b1;
  endtask

  // receive side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = !quiet && $urandom_range(0, 99) < 10;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      board.check_beat(out_sample, last_of_run, row_done);
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned rows;
    int unsigned len;
    bit          partial;
    board = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = MODE_VERT;
    in_valid = 1'b0;
    near_sample = '0;
    far_sample = '0;
    last_in_row = 1'b0;
    quiet = 1'b0;
    mode_writes = 0;
    modes_seen = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, one-sample rows, mode changes mid-row, saturation
    write_mode(MODE_VERT);
    send_pair(8'h00, 8'h00, 1'b0);
    send_pair(8'hFF, 8'hFF, 1'b0);
    send_pair(8'hFF, 8'h00, 1'b0);
    send_pair(8'h00, 8'hFF, 1'b1);
    send_pair(8'hAA, 8'h55, 1'b1);
    write_mode(MODE_HORIZ);
    send_pair(8'hFF, 8'h12, 1'b1);
    send_pair(8'h00, 8'hFF, 1'b0);
    send_pair(8'hFF, 8'h00, 1'b0);
    send_pair(8'h80, 8'h33, 1'b1);
    send_pair(8'hC8, 8'h01, 1'b0);
    write_mode(MODE_2X2);
    send_pair(8'hFF, 8'hFF, 1'b0);
    send_pair(8'h0A, 8'h14, 1'b1);
    send_pair(8'hFF, 8'hFF, 1'b1);
    send_pair(8'hFF, 8'hFF, 1'b0);
    write_mode(MODE_HORIZ);
    send_pair(8'hFF, 8'h00, 1'b0);
    send_pair(8'h00, 8'h00, 1'b1);
    write_mode(MODE_RESERVED);
    send_pair(8'h11, 8'hC8, 1'b0);
    send_pair(8'h63, 8'h03, 1'b1);
    write_mode(MODE_VERT);
    send_pair(8'h05, 8'h06, 1'b0);
    write_mode(MODE_HORIZ);
    send_pair(8'h07, 8'h08, 1'b1);

    // random rows, some cut short before a mode change
    phase = 0;
    while (board.pairs < ItemTarget) begin
      write_mode(phase < 4 ? 2'(phase) : 2'($urandom_range(0, 3)));
      quiet = (phase == 6 || phase == 7);
      rows = $urandom_range(2, 6);
      for (int r = 0; r < rows; r++) begin
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
        partial = (r == rows - 1) && ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++) begin
          send_pair(rand_byte(), rand_byte(), (i == len - 1) && !partial);
        end
        if ($urandom_range(0, 7) == 0) drain_beats();
      end
      phase++;
    end
    quiet = 1'b0;

    drain_beats();
    repeat (20) @(negedge clk);
    $display("covered %0d sample pairs, %0d output beats, %0d mode writes (codes seen %b)",
             board.pairs, board.beats, mode_writes, modes_seen);
    $display("rows cut mid-way across mode changes, with random stalls on both sides");
    if (board.errors == 0 && board.pending_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/jcfu_pkg.sv
rtl/jcfu_front.sv
rtl/jcfu_calc.sv
rtl/jcfu_emit.sv
rtl/jpeg_chroma_fancy_upsample_unit.sv
tb/jpeg_chroma_fancy_upsample_unit_tb.sv
